/* src/rmc_pkg.sv */
// Shared types and constants for the range membership curve block.
package rmc_pkg;

  localparam int unsigned VAL_W     = 32;
  localparam int unsigned DIST_W    = 33;
  localparam int unsigned REM_W     = 35;
  localparam int unsigned QUO_W     = 32;
  localparam int unsigned ACC_W     = 34;
  localparam int unsigned MEM_W     = 16;
  localparam int unsigned SHAPE_W   = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned N_TERMS   = 12;

  // end-to-end delay from an accepted request to its result strobe
  localparam int unsigned LATENCY = 72;

  // ln 2 in Q0.32
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // floor(2^32 / k) for the Taylor term divides
  localparam logic [31:0] RECIP [2:12] = '{
    32'd2147483648, 32'd1431655765, 32'd1073741824, 32'd858993459,
    32'd715827882,  32'd613566756,  32'd536870912,  32'd477218588,
    32'd429496729,  32'd390451572,  32'd357913941
  };

  localparam logic signed [31:0] LOW_CROSS_RST  = -32'sd65536000;
  localparam logic signed [31:0] HIGH_CROSS_RST = 32'sd65536000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_CROSS   = 3'd0,
    REG_LOW_CORE    = 3'd1,
    REG_HIGH_CORE   = 3'd2,
    REG_HIGH_CROSS  = 3'd3,
    REG_CURVE_SHAPE = 3'd4
  } cfg_reg_t;

  typedef enum logic [SHAPE_W-1:0] {
    SHAPE_BELL = 2'd0,
    SHAPE_S    = 2'd1,
    SHAPE_Z    = 2'd2
  } shape_t;

  // per-request side band: valid, result already known, and which value
  typedef struct packed {
    logic valid;
    logic fix;
    logic full;
  } rmc_tag_t;

endpackage

/* src/range_membership_curve.sv */
// Top level of the range membership curve: registers, legality flag, pipeline.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  -----------------------------
//  request   env_value, is_nodata                    start high, busy low
//  result    membership, config_legal                done strobe, one cycle
//  config    cfg_index, cfg_data                     cfg_we, taken at once
//
// One request per cycle while busy is low; the delay to each result is set mostly by
// the 32-stage divider and the 33-stage Taylor series chain.
// rst is synchronous; busy is high while it is held, low otherwise.
// The result side has no stall, so nothing in the pipeline ever waits.
module range_membership_curve import rmc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [VAL_W-1:0] env_value,
  input  logic                    is_nodata,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [VAL_W-1:0]        cfg_data,
  output logic                    done,
  output logic [MEM_W-1:0]        membership,
  output logic                    config_legal
);

  logic signed [VAL_W-1:0] low_cross, low_core, high_core, high_cross;
  logic [SHAPE_W-1:0]      curve_shape;
  logic                    legal_next;
  logic                    take;
  logic [DIST_W-1:0]       dist_mag, width;
  rmc_tag_t                f_tag, d_tag;
  logic [QUO_W-1:0]        quo;

  assign busy = rst;
  assign take = start & ~busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_cross   <= LOW_CROSS_RST;
      low_core    <= '0;
      high_core   <= '0;
      high_cross  <= HIGH_CROSS_RST;
      curve_shape <= SHAPE_BELL;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LOW_CROSS:   low_cross   <= cfg_data;
        REG_LOW_CORE:    low_core    <= cfg_data;
        REG_HIGH_CORE:   high_core   <= cfg_data;
        REG_HIGH_CROSS:  high_cross  <= cfg_data;
        REG_CURVE_SHAPE: curve_shape <= cfg_data[SHAPE_W-1:0];
        default: ;
      endcase
    end
  end

  // point ordering check for the current shape
  always_comb begin
    case (curve_shape)
      SHAPE_S: legal_next = low_cross < low_core;
      SHAPE_Z: legal_next = high_cross > high_core;
      default: legal_next = (low_cross < low_core) && (high_core >= low_core) &&
                            (high_cross > high_core);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      config_legal <= 1'b0;
    end else begin
      config_legal <= legal_next;
    end
  end

  rmc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .env_value   (env_value),
    .is_nodata   (is_nodata),
    .low_cross   (low_cross),
    .low_core    (low_core),
    .high_core   (high_core),
    .high_cross  (high_cross),
    .curve_shape (curve_shape),
    .dist_mag    (dist_mag),
    .width       (width),
    .tag         (f_tag)
  );

  rmc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .dist_mag (dist_mag),
    .width    (width),
    .tag_in   (f_tag),
    .quo      (quo),
    .tag_out  (d_tag)
  );

  rmc_exp u_exp (
    .clk        (clk),
    .rst        (rst),
    .quo        (quo),
    .tag_in     (d_tag),
    .membership (membership),
    .valid      (done)
  );

`ifndef ASSERT_OFF
  // every result strobe traces back to a request a fixed delay earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching request");

  // a nodata request yields zero membership
  a_nodata: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && !busy && is_nodata, LATENCY)) |-> (membership == '0))
    else $error("nodata request gave nonzero membership");
`endif

endmodule

/* src/rmc_front.sv */
// Side selection, distance and width, and the special-case flags.
module rmc_front import rmc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  logic signed [VAL_W-1:0]  env_value,
  input  logic                     is_nodata,
  input  logic signed [VAL_W-1:0]  low_cross,
  input  logic signed [VAL_W-1:0]  low_core,
  input  logic signed [VAL_W-1:0]  high_core,
  input  logic signed [VAL_W-1:0]  high_cross,
  input  logic [SHAPE_W-1:0]       curve_shape,
  output logic [DIST_W-1:0]        dist_mag,
  output logic [DIST_W-1:0]        width,
  output rmc_tag_t                 tag
);

  logic              in_core, use_low;
  logic signed [DIST_W-1:0] dv_next, dw_next;
  logic signed [DIST_W-1:0] s1_dv, s1_dw;
  rmc_tag_t          s1_tag, s2_tag;
  logic [DIST_W-1:0] s2_d, s2_w;
  rmc_tag_t          tag_next;

  // pick the side of the curve and whether the sample sits in the core
  always_comb begin
    case (curve_shape)
      SHAPE_S: begin
        in_core = env_value > low_core;
        use_low = 1'b1;
      end
      SHAPE_Z: begin
        in_core = env_value < high_core;
        use_low = 1'b0;
      end
      default: begin
        in_core = (env_value > low_core) && (env_value < high_core);
        use_low = env_value <= low_core;
      end
    endcase
    if (use_low) begin
      dv_next = {env_value[VAL_W-1], env_value} - {low_core[VAL_W-1], low_core};
      dw_next = {low_core[VAL_W-1], low_core} - {low_cross[VAL_W-1], low_cross};
    end else begin
      dv_next = {env_value[VAL_W-1], env_value} - {high_core[VAL_W-1], high_core};
      dw_next = {high_cross[VAL_W-1], high_cross} - {high_core[VAL_W-1], high_core};
    end
  end

  // stage 1: signed differences
  always_ff @(posedge clk) begin
    s1_dv <= dv_next;
    s1_dw <= dw_next;
    if (rst) begin
      s1_tag <= '0;
    end else begin
      s1_tag.valid <= take;
      s1_tag.fix   <= is_nodata | in_core;
      s1_tag.full  <= ~is_nodata & in_core;
    end
  end

  // stage 2: magnitudes
  always_ff @(posedge clk) begin
    s2_d <= s1_dv[DIST_W-1] ? DIST_W'(-s1_dv) : DIST_W'(s1_dv);
    s2_w <= s1_dw[DIST_W-1] ? DIST_W'(-s1_dw) : DIST_W'(s1_dw);
    if (rst) begin
      s2_tag <= '0;
    end else begin
      s2_tag <= s1_tag;
    end
  end

  // zero distance, zero width, ratio of four or more
  always_comb begin
    tag_next = s2_tag;
    if (!s2_tag.fix) begin
      if (s2_d == '0) begin
        tag_next.fix  = 1'b1;
        tag_next.full = 1'b1;
      end else if ((s2_w == '0) || ({2'b00, s2_d} >= {s2_w, 2'b00})) begin
        tag_next.fix  = 1'b1;
        tag_next.full = 1'b0;
      end
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    dist_mag <= s2_d;
    width    <= s2_w;
    if (rst) begin
      tag <= '0;
    end else begin
      tag <= tag_next;
    end
  end

endmodule

/* src/rmc_div.sv */
// Pipelined restoring divider: q = floor(d * 2^30 / w), one quotient bit per stage.
module rmc_div import rmc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [DIST_W-1:0] dist_mag,
  input  logic [DIST_W-1:0] width,
  input  rmc_tag_t          tag_in,
  output logic [QUO_W-1:0]  quo,
  output rmc_tag_t          tag_out
);

  logic [REM_W-1:0]  r_s [1:QUO_W];
  logic [DIST_W-1:0] w_s [1:QUO_W];
  logic [QUO_W-1:0]  q_s [1:QUO_W];
  rmc_tag_t          t_s [1:QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    logic [REM_W-1:0]  r_prev, r_in, cmp;
    logic [DIST_W-1:0] w_prev;
    logic [QUO_W-1:0]  q_prev;
    rmc_tag_t          t_prev;
    logic [REM_W:0]    diff;
    logic              ge;

    if (j == 0) begin : g_first
      assign r_prev = {2'b00, dist_mag};
      assign w_prev = width;
      assign q_prev = '0;
      assign t_prev = tag_in;
    end else begin : g_next
      assign r_prev = r_s[j];
      assign w_prev = w_s[j];
      assign q_prev = q_s[j];
      assign t_prev = t_s[j];
    end

    // first two bits compare against 2w and w, the rest shift then compare
    if (j == 0) begin : g_b31
      assign r_in = r_prev;
      assign cmp  = {1'b0, w_prev, 1'b0};
    end else if (j == 1) begin : g_b30
      assign r_in = r_prev;
      assign cmp  = {2'b00, w_prev};
    end else begin : g_bn
      assign r_in = {r_prev[REM_W-2:0], 1'b0};
      assign cmp  = {2'b00, w_prev};
    end

    assign diff = {1'b0, r_in} - {1'b0, cmp};
    assign ge   = ~diff[REM_W];

    always_ff @(posedge clk) begin
      r_s[j+1] <= ge ? diff[REM_W-1:0] : r_in;
      q_s[j+1] <= {q_prev[QUO_W-2:0], ge};
      w_s[j+1] <= w_prev;
      if (rst) begin
        t_s[j+1] <= '0;
      end else begin
        t_s[j+1] <= t_prev;
      end
    end
  end

  assign quo     = q_s[QUO_W];
  assign tag_out = t_s[QUO_W];

endmodule

/* src/rmc_exp.sv */
// Square, scale by ln 2, Taylor series for exp(-y), shift and round to Q0.16.
module rmc_exp import rmc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [QUO_W-1:0] quo,
  input  rmc_tag_t         tag_in,
  output logic [MEM_W-1:0] membership,
  output logic             valid
);

  logic [63:0]      sq;
  rmc_tag_t         e1_tag;
  logic [61:0]      yprod;

  logic [31:0]      term_s [1:N_TERMS];
  logic [31:0]      y_s    [1:N_TERMS];
  logic [ACC_W-1:0] acc_s  [1:N_TERMS];
  logic [3:0]       n_s    [1:N_TERMS];
  rmc_tag_t         tag_s  [1:N_TERMS];

  logic [ACC_W-1:0] f1_e;
  logic [3:0]       f1_n;
  rmc_tag_t         f1_tag;
  logic [ACC_W-1:0] m;
  logic [ACC_W:0]   rnd;
  logic [MEM_W-1:0] sat;

  // stage E1: square of the Q2.30 ratio
  always_ff @(posedge clk) begin
    sq <= 64'(quo) * 64'(quo);
    if (rst) begin
      e1_tag <= '0;
    end else begin
      e1_tag <= tag_in;
    end
  end

  // stage E2: integer part n, fraction times ln 2 gives y
  assign yprod = 62'(sq[59:30]) * 62'(LN2_Q32);

  always_ff @(posedge clk) begin
    y_s[1]    <= yprod[61:30];
    term_s[1] <= yprod[61:30];
    acc_s[1]  <= ACC_W'(64'h1_0000_0000);
    n_s[1]    <= sq[63:60];
    if (rst) begin
      tag_s[1] <= '0;
    end else begin
      tag_s[1] <= e1_tag;
    end
  end

  // three stages per Taylor term: product, reciprocal estimate, correction
  for (genvar k = 2; k <= N_TERMS; k++) begin : g_term
    localparam logic [3:0] K = 4'(k);
    logic [31:0]      x_a, x_b, y_a, y_b, est_b;
    logic [ACC_W-1:0] acc_a, acc_b;
    logic [3:0]       n_a, n_b;
    rmc_tag_t         t_a, t_b;
    logic [63:0]      prod, eprod;
    logic [35:0]      rem;

    assign prod  = 64'(term_s[k-1]) * 64'(y_s[k-1]);
    assign eprod = 64'(x_a) * 64'(RECIP[k]);
    assign rem   = {4'b0000, x_b} - (36'(est_b) * 36'(K));

    always_ff @(posedge clk) begin
      // A: next product, fold the previous term into the sum
      x_a   <= prod[63:32];
      acc_a <= ((k - 1) % 2 == 1) ? acc_s[k-1] - ACC_W'(term_s[k-1])
                                  : acc_s[k-1] + ACC_W'(term_s[k-1]);
      y_a   <= y_s[k-1];
      n_a   <= n_s[k-1];
      // B: quotient estimate, low by at most one
      est_b <= eprod[63:32];
      x_b   <= x_a;
      acc_b <= acc_a;
      y_b   <= y_a;
      n_b   <= n_a;
      // C: one correction step
      term_s[k] <= (rem >= 36'(K)) ? est_b + 32'd1 : est_b;
      acc_s[k]  <= acc_b;
      y_s[k]    <= y_b;
      n_s[k]    <= n_b;
      if (rst) begin
        t_a      <= '0;
        t_b      <= '0;
        tag_s[k] <= '0;
      end else begin
        t_a      <= tag_s[k-1];
        t_b      <= t_a;
        tag_s[k] <= t_b;
      end
    end
  end

  // stage F1: last term is even, added
  always_ff @(posedge clk) begin
    f1_e <= acc_s[N_TERMS] + ACC_W'(term_s[N_TERMS]);
    f1_n <= n_s[N_TERMS];
    if (rst) begin
      f1_tag <= '0;
    end else begin
      f1_tag <= tag_s[N_TERMS];
    end
  end

  // stage F2: scale by 2^-n, round, saturate, apply known results
  assign m   = f1_e >> f1_n;
  assign rnd = {1'b0, m} + (ACC_W+1)'(16'h8000);
  assign sat = (rnd[ACC_W:32] != '0) ? '1 : rnd[31:16];

  always_ff @(posedge clk) begin
    if (f1_tag.fix) begin
      membership <= f1_tag.full ? '1 : '0;
    end else begin
      membership <= sat;
    end
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= f1_tag.valid;
    end
  end

endmodule
